### hw/rtl/hill_cipher_2x2_mod26_unit_assert.svh
// assertion macros shared by the hill cipher modules
`ifndef HILL_CIPHER_2X2_MOD26_UNIT_ASSERT_SVH
`define HILL_CIPHER_2X2_MOD26_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// condition must hold in the same cycle
`define HILL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hill cipher check failed");
// condition must hold in the next cycle
`define HILL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hill cipher check failed");
`else
`define HILL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HILL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/hill_pkg.sv
package hill_pkg;

    localparam int unsigned Modulus = 26;

    // 26 * 9 keeps a*d - b*c non-negative
    localparam logic [10:0] DetBias = 11'd234;

    // floor(x * 2521 / 2^16) equals floor(x / 26) for every 11-bit x
    localparam logic [22:0] RecipMul   = 23'd2521;
    localparam logic [10:0] ModulusW11 = 11'd26;

    // cycles the derived key needs after a register write
    localparam logic [1:0] KeySettle = 2'd3;

    typedef enum logic [2:0] {
        RegKeyTopLeft     = 3'd0,
        RegKeyTopRight    = 3'd1,
        RegKeyBottomLeft  = 3'd2,
        RegKeyBottomRight = 3'd3,
        RegDecryptMode    = 3'd4
    } cfg_reg_t;

    // matrix in use and its error flag
    typedef struct packed {
        logic [4:0] m00;
        logic [4:0] m01;
        logic [4:0] m10;
        logic [4:0] m11;
        logic       err;
    } key_t;

    // one complete pair on its way to the multiply
    typedef struct packed {
        logic [4:0] p0;
        logic [4:0] p1;
        logic       last;
    } pair_t;

    // x mod 26 via reciprocal multiply, exact for 11-bit x
    function automatic logic [4:0] mod26(input logic [10:0] x);
        logic [22:0] prod;
        logic [10:0] qm;
        logic [10:0] r;
        prod = {12'b0, x} * RecipMul;
        qm   = {4'b0, prod[22:16]} * ModulusW11;
        r    = x - qm;
        return r[4:0];
    endfunction

    // additive inverse of a residue
    function automatic logic [4:0] neg26(input logic [4:0] r);
        logic [4:0] n;
        if (r == 5'd0)
        begin
            n = 5'd0;
        end
        else
        begin
            n = 5'd26 - r;
        end
        return n;
    endfunction

    // multiplicative inverse mod 26, zero where none exists
    function automatic logic [4:0] inv26(input logic [4:0] x);
        logic [4:0] v;
        case (x)
            5'd1:    v = 5'd1;
            5'd3:    v = 5'd9;
            5'd5:    v = 5'd21;
            5'd7:    v = 5'd15;
            5'd9:    v = 5'd3;
            5'd11:   v = 5'd19;
            5'd15:   v = 5'd7;
            5'd17:   v = 5'd23;
            5'd19:   v = 5'd11;
            5'd21:   v = 5'd5;
            5'd23:   v = 5'd17;
            5'd25:   v = 5'd25;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/hill_cipher_2x2_mod26_unit.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   symbol_value, end_of_message
// out       output     out_valid / out_ready first_out, second_out, key_error, last_pair
// cfg       input      cfg_write             cfg_index, cfg_data
//
// one value accepted per cycle unless key_busy or a full pipeline holds in_ready low; a pair
// result leaves through the pair register, product register and result register
// after reset and after each register write, input is held off while the determinant,
// inverse and adjugate pipeline refills
// a stalled output fills the result, product and pair registers before in_ready drops
module hill_cipher_2x2_mod26_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] symbol_value,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] first_out,
    output logic [4:0] second_out,
    output logic       key_error,
    output logic       last_pair,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [3:0] cfg_data
);

    logic            decrypt_mode;
    logic            key_busy;
    hill_pkg::key_t  key;
    logic            pair_take;
    logic            pair_valid;
    hill_pkg::pair_t pair;

    // key registers and derived matrix
    hill_key u_key (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .decrypt_mode (decrypt_mode),
        .key_busy     (key_busy),
        .key          (key)
    );

    // input reduction and pairing
    hill_pair u_pair (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .symbol_value   (symbol_value),
        .end_of_message (end_of_message),
        .decrypt_mode   (decrypt_mode),
        .key_busy       (key_busy),
        .pair_take      (pair_take),
        .pair_valid     (pair_valid),
        .pair           (pair)
    );

    // matrix multiply and result register
    hill_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair       (pair),
        .key        (key),
        .pair_take  (pair_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .first_out  (first_out),
        .second_out (second_out),
        .key_error  (key_error),
        .last_pair  (last_pair)
    );

endmodule

### hw/rtl/hill_key.sv
`include "hill_cipher_2x2_mod26_unit_assert.svh"

module hill_key (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [3:0]        cfg_data,
    output logic              decrypt_mode,
    output logic              key_busy,
    output hill_pkg::key_t    key
);

    logic [3:0] a_reg;
    logic [3:0] b_reg;
    logic [3:0] c_reg;
    logic [3:0] d_reg;
    logic       mode_reg;
    logic [1:0] settle_reg;
    logic [1:0] settle_next;

    logic [7:0] ad_reg;
    logic [7:0] bc_reg;
    logic [4:0] det_reg;
    logic [8:0] dinv_reg;
    logic [8:0] binv_reg;
    logic [8:0] cinv_reg;
    logic [8:0] ainv_reg;
    logic       noinv_reg;
    hill_pkg::key_t key_reg;
    hill_pkg::key_t key_next;

    logic [10:0] det_sum;
    logic [4:0]  inv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= 4'd1;
            b_reg    <= 4'd0;
            c_reg    <= 4'd0;
            d_reg    <= 4'd1;
            mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (hill_pkg::cfg_reg_t'(cfg_index))
                hill_pkg::RegKeyTopLeft:     a_reg    <= cfg_data;
                hill_pkg::RegKeyTopRight:    b_reg    <= cfg_data;
                hill_pkg::RegKeyBottomLeft:  c_reg    <= cfg_data;
                hill_pkg::RegKeyBottomRight: d_reg    <= cfg_data;
                hill_pkg::RegDecryptMode:    mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // settle count while the derived key catches up
    always_comb
    begin
        if (cfg_write)
        begin
            settle_next = hill_pkg::KeySettle;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
        else
        begin
            settle_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= hill_pkg::KeySettle;
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    // determinant terms, then determinant mod 26
    assign det_sum = {3'b0, ad_reg} + hill_pkg::DetBias - {3'b0, bc_reg};
    assign inv     = hill_pkg::inv26(det_reg);

    // adjugate scaled by the inverse, then reduced and selected by mode
    always_comb
    begin
        key_next.err = mode_reg & noinv_reg;
        if (mode_reg)
        begin
            key_next.m00 = hill_pkg::mod26({2'b0, dinv_reg});
            key_next.m01 = hill_pkg::neg26(hill_pkg::mod26({2'b0, binv_reg}));
            key_next.m10 = hill_pkg::neg26(hill_pkg::mod26({2'b0, cinv_reg}));
            key_next.m11 = hill_pkg::mod26({2'b0, ainv_reg});
        end
        else
        begin
            key_next.m00 = {1'b0, a_reg};
            key_next.m01 = {1'b0, b_reg};
            key_next.m10 = {1'b0, c_reg};
            key_next.m11 = {1'b0, d_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        ad_reg    <= {4'b0, a_reg} * {4'b0, d_reg};
        bc_reg    <= {4'b0, b_reg} * {4'b0, c_reg};
        det_reg   <= hill_pkg::mod26(det_sum);
        dinv_reg  <= {5'b0, d_reg} * {4'b0, inv};
        binv_reg  <= {5'b0, b_reg} * {4'b0, inv};
        cinv_reg  <= {5'b0, c_reg} * {4'b0, inv};
        ainv_reg  <= {5'b0, a_reg} * {4'b0, inv};
        noinv_reg <= (inv == 5'd0);
        key_reg   <= key_next;
    end

    assign decrypt_mode = mode_reg;
    assign key_busy     = (settle_reg != 2'd0);
    assign key          = key_reg;

    `HILL_ASSERT_NEXT(a_write_holds_off, clk, rst_n, cfg_write, key_busy)
    `HILL_ASSERT_NOW(a_err_only_decrypt, clk, rst_n, !key_busy && key_reg.err, mode_reg)

endmodule

### hw/rtl/hill_pair.sv
`include "hill_cipher_2x2_mod26_unit_assert.svh"

module hill_pair (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        symbol_value,
    input  logic              end_of_message,
    input  logic              decrypt_mode,
    input  logic              key_busy,
    input  logic              pair_take,
    output logic              pair_valid,
    output hill_pkg::pair_t   pair
);

    logic            holding_reg;
    logic            holding_next;
    logic [4:0]      held_reg;
    logic [4:0]      held_next;
    logic            pair_valid_reg;
    logic            pair_valid_next;
    hill_pkg::pair_t pair_reg;
    hill_pkg::pair_t pair_next;

    logic       accept;
    logic       form_pair;
    logic [4:0] v;

    // input transfer and reduction
    assign in_ready  = !key_busy && (!pair_valid_reg || pair_take);
    assign accept    = in_valid && in_ready;
    assign v         = hill_pkg::mod26({3'b0, symbol_value});
    assign form_pair = accept && (holding_reg || (end_of_message && !decrypt_mode));

    // holder and pair assembly
    always_comb
    begin
        holding_next = holding_reg;
        held_next    = held_reg;
        if (accept)
        begin
            holding_next = !holding_reg && !end_of_message;
            if (!holding_reg && !end_of_message)
            begin
                held_next = v;
            end
            else
            begin
                held_next = 5'd0;
            end
        end

        pair_next.p0   = holding_reg ? held_reg : v;
        pair_next.p1   = holding_reg ? v : 5'd0;
        pair_next.last = end_of_message;

        if (form_pair)
        begin
            pair_valid_next = 1'b1;
        end
        else if (pair_take)
        begin
            pair_valid_next = 1'b0;
        end
        else
        begin
            pair_valid_next = pair_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg    <= 1'b0;
            held_reg       <= 5'd0;
            pair_valid_reg <= 1'b0;
        end
        else
        begin
            holding_reg    <= holding_next;
            held_reg       <= held_next;
            pair_valid_reg <= pair_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (form_pair)
        begin
            pair_reg <= pair_next;
        end
    end

    assign pair_valid = pair_valid_reg;
    assign pair       = pair_reg;

    `HILL_ASSERT_NOW(a_busy_blocks_input, clk, rst_n, key_busy, !in_ready)

endmodule

### hw/rtl/hill_mix.sv
`include "hill_cipher_2x2_mod26_unit_assert.svh"

module hill_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    input  hill_pkg::pair_t   pair,
    input  hill_pkg::key_t    key,
    output logic              pair_take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [4:0]        first_out,
    output logic [4:0]        second_out,
    output logic              key_error,
    output logic              last_pair
);

    logic        prod_valid_reg;
    logic [10:0] sum0_reg;
    logic [10:0] sum1_reg;
    logic        perr_reg;
    logic        plast_reg;

    logic        out_valid_reg;
    logic [4:0]  first_reg;
    logic [4:0]  second_reg;
    logic        err_reg;
    logic        last_reg;

    logic        out_free;
    logic        prod_free;
    logic        prod_move;
    logic [9:0]  pr00;
    logic [9:0]  pr01;
    logic [9:0]  pr10;
    logic [9:0]  pr11;

    // stage enables
    assign out_free  = !out_valid_reg || out_ready;
    assign prod_free = !prod_valid_reg || out_free;
    assign pair_take = pair_valid && prod_free;
    assign prod_move = prod_valid_reg && out_free;

    // matrix times pair
    assign pr00 = {5'b0, key.m00} * {5'b0, pair.p0};
    assign pr01 = {5'b0, key.m01} * {5'b0, pair.p1};
    assign pr10 = {5'b0, key.m10} * {5'b0, pair.p0};
    assign pr11 = {5'b0, key.m11} * {5'b0, pair.p1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_free)
            begin
                prod_valid_reg <= pair_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // product sums
    always_ff @(posedge clk)
    begin
        if (pair_take)
        begin
            sum0_reg  <= {1'b0, pr00} + {1'b0, pr01};
            sum1_reg  <= {1'b0, pr10} + {1'b0, pr11};
            perr_reg  <= key.err;
            plast_reg <= pair.last;
        end
    end

    // reduction and result register
    always_ff @(posedge clk)
    begin
        if (prod_move)
        begin
            first_reg  <= perr_reg ? 5'd0 : hill_pkg::mod26(sum0_reg);
            second_reg <= perr_reg ? 5'd0 : hill_pkg::mod26(sum1_reg);
            err_reg    <= perr_reg;
            last_reg   <= plast_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign first_out  = first_reg;
    assign second_out = second_reg;
    assign key_error  = err_reg;
    assign last_pair  = last_reg;

    `HILL_ASSERT_NOW(a_error_zero, clk, rst_n, out_valid_reg && err_reg, first_reg == 5'd0 && second_reg == 5'd0)
    `HILL_ASSERT_NOW(a_result_range, clk, rst_n, out_valid_reg, first_reg < 5'd26 && second_reg < 5'd26)

endmodule

### test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClkPeriod   = 10;
    localparam int ResetCycles = 9;
    // three pipeline stages plus key refill after a write, with margin
    localparam int DrainCycles = 10;
    localparam int StallLimit  = 5000;
    localparam int ChunkItems  = 107;
    localparam int Mod         = 26;

    // pair predictor and store of expected pairs
    class hill_scoreboard;
        typedef struct packed {
            logic [4:0] first_val;
            logic [4:0] second_val;
            logic       err;
            logic       last;
        } pair_out_t;

        pair_out_t  expected_pairs[$];
        logic [3:0] key_a;
        logic [3:0] key_b;
        logic [3:0] key_c;
        logic [3:0] key_d;
        logic       decrypt;
        logic [4:0] held;
        logic       holding;
        int         errors;

        function new();
            key_a   = 4'd1;
            key_b   = 4'd0;
            key_c   = 4'd0;
            key_d   = 4'd1;
            decrypt = 1'b0;
            held    = 5'd0;
            holding = 1'b0;
            errors  = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [3:0] data);
            case (idx)
                hill_pkg::RegKeyTopLeft:     key_a = data;
                hill_pkg::RegKeyTopRight:    key_b = data;
                hill_pkg::RegKeyBottomLeft:  key_c = data;
                hill_pkg::RegKeyBottomRight: key_d = data;
                hill_pkg::RegDecryptMode:    decrypt = data[0];
                default:                     ;
            endcase
        endfunction

        // search for x * i = 1 mod 26, zero if none
        function int inverse26(int x);
            for (int i = 1; i < Mod; i++)
            begin
                if ((x * i) % Mod == 1)
                begin
                    return i;
                end
            end
            return 0;
        endfunction

        function int key_det(int a, int b, int c, int d);
            return ((a * d - b * c) % Mod + Mod) % Mod;
        endfunction

        function bit key_invertible(int a, int b, int c, int d);
            return inverse26(key_det(a, b, c, d)) != 0;
        endfunction

        function pair_out_t transform_pair(int p0, int p1, logic last);
            int        m00;
            int        m01;
            int        m10;
            int        m11;
            int        inv;
            pair_out_t r;
            r.last = last;
            r.err  = 1'b0;
            if (!decrypt)
            begin
                m00 = key_a;
                m01 = key_b;
                m10 = key_c;
                m11 = key_d;
            end
            else
            begin
                inv = inverse26(key_det(key_a, key_b, key_c, key_d));
                if (inv == 0)
                begin
                    r.first_val  = 5'd0;
                    r.second_val = 5'd0;
                    r.err        = 1'b1;
                    return r;
                end
                // inverse key from the adjugate
                m00 = (key_d * inv) % Mod;
                m01 = (Mod - (key_b * inv) % Mod) % Mod;
                m10 = (Mod - (key_c * inv) % Mod) % Mod;
                m11 = (key_a * inv) % Mod;
            end
            r.first_val  = 5'((m00 * p0 + m01 * p1) % Mod);
            r.second_val = 5'((m10 * p0 + m11 * p1) % Mod);
            return r;
        endfunction

        // accepted input transfer
        function void note_input(logic [7:0] sym, logic eom);
            int v;
            v = int'(sym) % Mod;
            if (holding)
            begin
                holding = 1'b0;
                expected_pairs.insert(expected_pairs.size(), transform_pair(held, v, eom));
                held = 5'd0;
            end
            else if (eom)
            begin
                // odd trailing value: padded when encrypting, dropped when decrypting
                if (!decrypt)
                begin
                    expected_pairs.insert(expected_pairs.size(), transform_pair(v, 0, 1'b1));
                end
            end
            else
            begin
                held    = 5'(v);
                holding = 1'b1;
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // accepted output transfer
        task check_result(logic [4:0] f, logic [4:0] s, logic e, logic l);
            pair_out_t exp;
            if (expected_pairs.size() == 0)
            begin
                report($sformatf("unexpected pair %0d %0d err=%0d last=%0d", f, s, e, l));
                return;
            end
            exp = expected_pairs.pop_front();
            if (f !== exp.first_val)
            begin
                report($sformatf("first_out %0d, want %0d", f, exp.first_val));
            end
            if (s !== exp.second_val)
            begin
                report($sformatf("second_out %0d, want %0d", s, exp.second_val));
            end
            if (e !== exp.err)
            begin
                report($sformatf("key_error %0d, want %0d", e, exp.err));
            end
            if (l !== exp.last)
            begin
                report($sformatf("last_pair %0d, want %0d", l, exp.last));
            end
        endtask
    endclass

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic [7:0] symbol_value   = 8'd0;
    logic       end_of_message = 1'b0;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic [4:0] first_out;
    logic [4:0] second_out;
    logic       key_error;
    logic       last_pair;
    logic       cfg_write      = 1'b0;
    logic [2:0] cfg_index      = 3'd0;
    logic [3:0] cfg_data       = 4'd0;

    hill_scoreboard sb;
    int send_idle_pct = 29;
    int recv_idle_pct = 77;
    int stall_cycles  = 0;

    hill_cipher_2x2_mod26_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .symbol_value   (symbol_value),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .first_out      (first_out),
        .second_out     (second_out),
        .key_error      (key_error),
        .last_pair      (last_pair),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    // one input transfer, with random idle cycles ahead of it
    task send_symbol(logic [7:0] sym, logic eom);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        symbol_value   <= sym;
        end_of_message <= eom;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_input(sym, eom);
    endtask

    // hold input until every expected pair has come, then let the pipe settle
    task wait_drained(int settle);
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() > 0);
        repeat (settle) @(posedge clk);
    endtask

    // write all five registers, optionally also the unused indexes
    task program_key(logic [3:0] a, logic [3:0] b, logic [3:0] c, logic [3:0] d,
                     logic dec, bit junk);
        logic [3:0] vals[5];
        logic [3:0] junk_data;
        vals = '{a, b, c, d, {3'd0, dec}};
        for (int i = 0; i <= int'(hill_pkg::RegDecryptMode); i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(3'(i), vals[i]);
        end
        if (junk)
        begin
            for (int i = int'(hill_pkg::RegDecryptMode) + 1; i < 8; i++)
            begin
                junk_data  = 4'($urandom_range(0, 15));
                cfg_write <= 1'b1;
                cfg_index <= 3'(i);
                cfg_data  <= junk_data;
                @(posedge clk);
                sb.set_reg(3'(i), junk_data);
            end
        end
        cfg_write <= 1'b0;
    endtask

    // a message of random length, random content
    task send_message(int len);
        for (int k = 0; k < len; k++)
        begin
            send_symbol(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    // output side: check and random stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_result(first_out, second_out, key_error, last_pair);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= StallLimit)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int         sent;
        int         msg_num;
        int         len;
        int         g;
        logic [3:0] ka;
        logic [3:0] kb;
        logic [3:0] kc;
        logic [3:0] kd;
        logic       dec;

        sb = new();
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key is identity in encrypt mode: field extremes and padding
        send_symbol(8'd0, 1'b0);
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd25, 1'b0);
        send_symbol(8'd26, 1'b1);
        send_symbol(8'd77, 1'b1);
        send_symbol(8'd51, 1'b0);
        send_symbol(8'd52, 1'b0);
        send_symbol(8'd128, 1'b1);
        wait_drained(DrainCycles);

        // invertible key, encrypt; unused indexes must be ignored
        program_key(4'd3, 4'd3, 4'd2, 4'd5, 1'b0, 1'b1);
        send_symbol(8'd7, 1'b0);
        send_symbol(8'd19, 1'b1);
        send_symbol(8'd200, 1'b1);
        wait_drained(DrainCycles);

        // same key, decrypt; odd trailing value dropped
        program_key(4'd3, 4'd3, 4'd2, 4'd5, 1'b1, 1'b0);
        send_symbol(8'd15, 1'b0);
        send_symbol(8'd240, 1'b1);
        send_symbol(8'd9, 1'b1);
        wait_drained(DrainCycles);

        // key entries above 9, singular key in decrypt mode
        program_key(4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 1'b0);
        send_symbol(8'd1, 1'b0);
        send_symbol(8'd2, 1'b1);
        wait_drained(DrainCycles);

        // largest key, encrypt, largest values
        program_key(4'd15, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0);
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd255, 1'b1);
        wait_drained(DrainCycles);

        // zero key, decrypt: error pair and a dropped trailing value
        program_key(4'd0, 4'd0, 4'd0, 4'd0, 1'b1, 1'b0);
        send_symbol(8'd100, 1'b0);
        send_symbol(8'd3, 1'b1);
        send_symbol(8'd5, 1'b1);
        wait_drained(DrainCycles);

        // random part in three idle profiles
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 77;
                end
                1:
                begin
                    send_idle_pct = 77;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < 5; chunk++)
            begin
                g = phase * 5 + chunk;
                case (g)
                    0:       {ka, kb, kc, kd, dec} = {4'd0, 4'd0, 4'd0, 4'd0, 1'b0};
                    1:       {ka, kb, kc, kd, dec} = {4'd15, 4'd15, 4'd15, 4'd15, 1'b1};
                    2:       {ka, kb, kc, kd, dec} = {4'd15, 4'd0, 4'd0, 4'd15, 1'b1};
                    3:       {ka, kb, kc, kd, dec} = {4'd15, 4'd15, 4'd15, 4'd15, 1'b0};
                    default:
                    begin
                        dec = 1'($urandom_range(0, 1));
                        // decrypt keys mostly invertible so real pairs dominate
                        do
                        begin
                            ka = 4'($urandom_range(0, 15));
                            kb = 4'($urandom_range(0, 15));
                            kc = 4'($urandom_range(0, 15));
                            kd = 4'($urandom_range(0, 15));
                        end
                        while (dec && $urandom_range(0, 3) != 0 &&
                               !sb.key_invertible(ka, kb, kc, kd));
                    end
                endcase
                program_key(ka, kb, kc, kd, dec, $urandom_range(0, 3) == 0);
                sent    = 0;
                msg_num = 0;
                while (sent < ChunkItems)
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                    // sender holds off mid-message until the output side is empty
                    if (msg_num == 3)
                    begin
                        send_symbol(8'($urandom_range(0, 255)), 1'b0);
                        wait_drained(0);
                        sent++;
                    end
                    send_message(len);
                    sent += len;
                    msg_num++;
                end
                wait_drained(DrainCycles);
            end
        end

        if (sb.errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
